[design/lrol_pkg.sv]
// Shared types and constants for the LRU recency order list unit.
package lrol_pkg;

  // Fixed field widths of the channel payloads
  localparam int ID_W  = 8;
  localparam int CNT_W = 5;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_PROMOTE   = 2'd1,
    OP_POP_FRONT = 2'd2,
    OP_POP_BACK  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t         opcode;
    logic [ID_W-1:0] entry_id;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  removed_id;
    logic             removed_valid;
    logic [CNT_W-1:0] entry_count;
  } result_t;

endpackage

[design/lrol_ifs.sv]
// Valid/ready channel interfaces for the operation and result transactions.
interface lrol_in_if import lrol_pkg::*; ();
  logic            valid;
  logic            ready;
  opcode_t         opcode;
  logic [ID_W-1:0] entry_id;

  modport source (output valid, output opcode, output entry_id, input ready);
  modport sink   (input valid, input opcode, input entry_id, output ready);
endinterface

interface lrol_out_if import lrol_pkg::*; ();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [ID_W-1:0]  removed_id;
  logic             removed_valid;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, output status, output removed_id, output removed_valid,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input removed_id, input removed_valid,
                  input entry_count, output ready);
endinterface

[design/lru_recency_order_list_unit.sv]
// Recency list of cache entry handles, most recent first, with insert, promote
// and front/back eviction. One operation enters per clock cycle. An accepted
// operation is held in an input register; a combinational compare-and-shift
// over the slot registers computes its outcome, which lands in the result
// register and is offered on the output from there. The list state is updated
// at the same edge that loads the result register, so back-to-back operations
// see each other's effect with no bubble. The sustained rate of one per cycle
// is set by that update of all CAPACITY slots at once; it drops only while the
// result sink stalls.
module lru_recency_order_list_unit import lrol_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int HANDLE_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  lrol_in_if.sink    in_ch,
  lrol_out_if.source out_ch
);

  in_item_t in_item;
  in_item_t item;
  logic     item_vld;
  logic     out_can;
  logic     step;
  result_t  res;
  result_t  out_res;

  assign in_item.opcode   = in_ch.opcode;
  assign in_item.entry_id = in_ch.entry_id;

  // Held operation executes when the result register can take its result
  assign step = item_vld && out_can;

  lrol_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_item  (in_item),
    .in_ready (in_ch.ready),
    .take     (step),
    .vld      (item_vld),
    .item     (item)
  );

  lrol_list #(
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_list (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item),
    .res   (res)
  );

  lrol_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res       (res),
    .can_load  (out_can),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.status        = out_res.status;
  assign out_ch.removed_id    = out_res.removed_id;
  assign out_ch.removed_valid = out_res.removed_valid;
  assign out_ch.entry_count   = out_res.entry_count;

endmodule

[design/lrol_in_reg.sv]
// Input register stage: holds one accepted operation until the list consumes it.
module lrol_in_reg import lrol_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     in_ready,
  input  logic     take,
  output logic     vld,
  output in_item_t item
);

  logic     vld_r;
  in_item_t item_r;

  // Free when empty or when the held transaction moves on this cycle
  assign in_ready = !vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

[design/lrol_list.sv]
// Recency list storage with combinational insert, promote and remove logic.
module lrol_list import lrol_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int HANDLE_BITS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  in_item_t item,
  output result_t  res
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic [HANDLE_BITS-1:0] slot_r   [CAPACITY];
  logic [HANDLE_BITS-1:0] slot_nxt [CAPACITY];
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;

  logic [HANDLE_BITS-1:0] id;
  logic [CAPACITY-1:0]    match;
  logic [CAPACITY-1:0]    seen;     // a match exists at a lower slot
  logic                   found;
  logic                   full;
  logic                   empty;
  logic [IW-1:0]          back_idx;

  // Handle compare against every occupied slot, first hit wins
  always_comb begin
    id = HANDLE_BITS'(item.entry_id);
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CW'(i) < count_r) && (slot_r[i] == id);
    end
    seen[0] = 1'b0;
    for (int i = 1; i < CAPACITY; i++) begin
      seen[i] = seen[i-1] | match[i-1];
    end
    found = seen[CAPACITY-1] | match[CAPACITY-1];
  end

  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);
  assign back_idx = IW'(count_r - CW'(1));

  // Next list contents and the result of the operation
  always_comb begin
    logic [HANDLE_BITS-1:0] removed;
    slot_nxt          = slot_r;
    count_nxt         = count_r;
    removed           = '0;
    res.status        = ST_OK;
    res.removed_valid = 1'b0;
    case (item.opcode)
      OP_INSERT: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          slot_nxt[0] = id;
          for (int i = 1; i < CAPACITY; i++) begin
            slot_nxt[i] = slot_r[i-1];
          end
          count_nxt = count_r + CW'(1);
        end
      end
      OP_PROMOTE: begin
        if (!found) begin
          res.status = ST_NOT_FOUND;
        end else begin
          // slots up to and including the hit shift back by one
          slot_nxt[0] = id;
          for (int i = 1; i < CAPACITY; i++) begin
            if (!seen[i]) begin
              slot_nxt[i] = slot_r[i-1];
            end
          end
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          removed           = slot_r[0];
          res.removed_valid = 1'b1;
          for (int i = 0; i < CAPACITY - 1; i++) begin
            slot_nxt[i] = slot_r[i+1];
          end
          count_nxt = count_r - CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          removed           = slot_r[back_idx];
          res.removed_valid = 1'b1;
          count_nxt         = count_r - CW'(1);
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    res.removed_id  = ID_W'(removed);
    res.entry_count = CNT_W'(count_nxt);
  end

  // Slot contents: only occupied slots are ever read
  always_ff @(posedge clk) begin
    if (step) begin
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (step) begin
      count_r <= count_nxt;
    end
  end

endmodule

[design/lrol_out_reg.sv]
// Result register: holds one result transaction until the sink takes it.
module lrol_out_reg import lrol_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    vld_r;
  result_t res_r;

  assign can_load = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

[design/lrol_checker.sv]
// Port-level checks for the LRU recency order list unit, bound to the top level.
module lrol_checker import lrol_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input status_t          out_status,
  input logic [ID_W-1:0]  out_removed_id,
  input logic             out_removed_valid,
  input logic [CNT_W-1:0] out_entry_count
);

  // A stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // A stalled result transaction keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_removed_id) &&
      $stable(out_removed_valid) && $stable(out_entry_count))
    else $error("result payload changed while stalled");

  // Reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Empty and full reports agree with the count
  a_status_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != ST_EMPTY ||
                   (out_entry_count == '0 && !out_removed_valid && out_removed_id == '0)) &&
                  (out_status != ST_FULL || out_entry_count == CNT_W'(CAPACITY)))
    else $error("status inconsistent with entry count");

endmodule

bind lru_recency_order_list_unit lrol_checker #(
  .CAPACITY (CAPACITY)
) u_lrol_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_removed_id    (out_ch.removed_id),
  .out_removed_valid (out_ch.removed_valid),
  .out_entry_count   (out_ch.entry_count)
);
